@@ src/hdf_pkg.sv @@
// shared types and constants for the heat diffusion step block
package hdf_pkg;

    localparam int VAL_W = 16;
    localparam int LAP_W = 18;
    localparam int PROD_W = 35;
    localparam int INC_W = PROD_W - 16;
    localparam int SUM_W = 20;

    localparam logic [15:0] GAIN_RESET = 16'd31207;
    localparam logic [15:0] LEFT_RESET = 16'd16384;
    localparam logic [15:0] RIGHT_RESET = 16'hC000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic shift;
        logic step;
    } upd_ctrl_t;

endpackage

@@ src/hdf_chain.sv @@
// row of temperature cells that shifts one place toward the head per cycle while shift is high
module hdf_chain #(
    parameter int CELLS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              shift,
    input  logic signed [hdf_pkg::VAL_W-1:0]  tail_in,
    output logic signed [hdf_pkg::VAL_W-1:0]  head,
    output logic signed [hdf_pkg::VAL_W-1:0]  second
);

    logic signed [hdf_pkg::VAL_W-1:0] cells_reg [CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELLS; k++)
            begin
                cells_reg[k] <= '0;
            end
        end
        else if (shift)
        begin
            for (int k = 0; k < CELLS - 1; k++)
            begin
                cells_reg[k] <= cells_reg[k + 1];
            end
            cells_reg[CELLS-1] <= tail_in;
        end
    end

    assign head = cells_reg[0];
    assign second = cells_reg[1];

endmodule

@@ src/hdf_update.sv @@
// update stage: laplacian times gain, registered, then round, add to the cell and saturate; reads pass the cell through
module hdf_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hdf_pkg::upd_ctrl_t                ctrl,
    input  logic        [15:0]                gain,
    input  logic signed [hdf_pkg::VAL_W-1:0]  west,
    input  logic signed [hdf_pkg::VAL_W-1:0]  here,
    input  logic signed [hdf_pkg::VAL_W-1:0]  east,
    output logic signed [hdf_pkg::VAL_W-1:0]  result
);

    logic signed [hdf_pkg::LAP_W-1:0]  lap;
    logic signed [hdf_pkg::PROD_W-1:0] prod_next;
    logic signed [hdf_pkg::PROD_W-1:0] prod_reg;
    logic signed [hdf_pkg::VAL_W-1:0]  here_reg;
    logic                              step_reg;
    logic signed [hdf_pkg::PROD_W-1:0] biased;
    logic signed [hdf_pkg::INC_W-1:0]  inc;
    logic signed [hdf_pkg::SUM_W-1:0]  sum;

    assign lap = {{2{west[15]}}, west} - {here[15], here, 1'b0} + {{2{east[15]}}, east};
    assign prod_next = hdf_pkg::PROD_W'($signed({1'b0, gain})) * hdf_pkg::PROD_W'(lap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            step_reg <= ctrl.step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prod_reg <= prod_next;
            here_reg <= here;
        end
    end

    // round to nearest, ties upward
    assign biased = prod_reg + hdf_pkg::PROD_W'(32768);
    assign inc = biased[hdf_pkg::PROD_W-1:16];
    assign sum = {{(hdf_pkg::SUM_W-hdf_pkg::VAL_W){here_reg[15]}}, here_reg}
               + {{(hdf_pkg::SUM_W-hdf_pkg::INC_W){inc[hdf_pkg::INC_W-1]}}, inc};

    always_comb
    begin
        if (!step_reg)
        begin
            result = here_reg;
        end
        else if (sum > hdf_pkg::SUM_W'(32767))
        begin
            result = 16'sh7FFF;
        end
        else if (sum < -hdf_pkg::SUM_W'(32768))
        begin
            result = 16'sh8000;
        end
        else
        begin
            result = sum[hdf_pkg::VAL_W-1:0];
        end
    end

endmodule

@@ src/heat_diffusion_ftcs_step.sv @@
// top level of the one-dimensional heat diffusion step block
//
// Holds CELLS signed Q1.14 temperatures in a ring of cells, all zero after
// reset. The input channel (in_valid/in_ready) takes one word: mode 0
// advances the field by one explicit diffusion step, mode 1 reads the cell
// given by cell_index. Each word gives exactly one result word on the output
// channel (out_valid/out_ready): step_done 1 and cell_value 0 after a step,
// or step_done 0 and the cell value after a read (0 for an index past the
// field).
// Every word rotates the whole ring once through the single update stage,
// one cell per cycle, and then hands its result to the output register.
// in_ready is high only while the block is idle, so it takes no new word
// before the last one has left for the output register.
// The output register holds its word while out_ready is low; a finished word
// waits inside the block until that register frees up, and in_ready stays
// low meanwhile.
// gain, left_boundary and right_boundary are written through cfg_we,
// cfg_index and cfg_data; reset loads their defaults. The user must write
// them only while the block is idle; the block itself does not enforce it.
module heat_diffusion_ftcs_step #(
    parameter int CELLS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [7:0]                            cell_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [hdf_pkg::VAL_W-1:0]      cell_value,
    output logic                                  step_done,
    input  logic                                  cfg_we,
    input  logic [hdf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                           cfg_data
);

    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    hdf_pkg::state_t state_reg, state_next;

    logic [15:0]                        gain_reg;
    logic signed [hdf_pkg::VAL_W-1:0]   left_reg;
    logic signed [hdf_pkg::VAL_W-1:0]   right_reg;

    logic [CNT_W-1:0]                   cnt_reg;
    logic                               mode_reg;
    logic [7:0]                         idx_reg;
    logic signed [hdf_pkg::VAL_W-1:0]   west_reg;
    logic signed [hdf_pkg::VAL_W-1:0]   rd_reg;

    logic                               out_valid_reg;
    logic signed [hdf_pkg::VAL_W-1:0]   cell_value_reg;
    logic                               step_done_reg;

    logic                               accept;
    logic                               shift;
    logic                               load;
    logic                               last;
    logic                               hit;
    logic signed [hdf_pkg::VAL_W-1:0]   head;
    logic signed [hdf_pkg::VAL_W-1:0]   second;
    logic signed [hdf_pkg::VAL_W-1:0]   east;
    logic signed [hdf_pkg::VAL_W-1:0]   tail_in;
    hdf_pkg::upd_ctrl_t                 upd_ctrl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= hdf_pkg::GAIN_RESET;
            left_reg <= hdf_pkg::LEFT_RESET;
            right_reg <= hdf_pkg::RIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hdf_pkg::REG_GAIN:  gain_reg <= cfg_data;
                hdf_pkg::REG_LEFT:  left_reg <= cfg_data;
                hdf_pkg::REG_RIGHT: right_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // control state machine
    assign last = (cnt_reg == CNT_W'(CELLS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hdf_pkg::ST_IDLE: if (in_valid) state_next = hdf_pkg::ST_RUN;
            hdf_pkg::ST_RUN:  if (last) state_next = hdf_pkg::ST_DONE;
            hdf_pkg::ST_DONE: if (!out_valid_reg || out_ready) state_next = hdf_pkg::ST_IDLE;
            default:          state_next = hdf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        shift = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            hdf_pkg::ST_IDLE: in_ready = 1'b1;
            hdf_pkg::ST_RUN:  shift = 1'b1;
            hdf_pkg::ST_DONE: load = !out_valid_reg || out_ready;
            default:          ;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdf_pkg::ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (shift)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the head cell seen on pass j is cell j of the field
    assign hit = shift && mode_reg && (cnt_reg < CNT_W'(CELLS))
               && (CMP_W'(cnt_reg) == CMP_W'(idx_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            idx_reg <= cell_index;
            west_reg <= left_reg;
            rd_reg <= '0;
        end
        else
        begin
            if (shift)
            begin
                west_reg <= head;
            end
            if (hit)
            begin
                rd_reg <= head;
            end
        end
        if (load)
        begin
            cell_value_reg <= mode_reg ? rd_reg : '0;
            step_done_reg <= !mode_reg;
        end
    end

    // the last cell sees the right boundary, the slot behind it holds no field data
    assign east = (cnt_reg == CNT_W'(CELLS - 1)) ? right_reg : second;

    assign upd_ctrl.shift = shift;
    assign upd_ctrl.step = !mode_reg;

    hdf_chain #(
        .CELLS(CELLS)
    ) u_chain (
        .clk(clk),
        .rst_n(rst_n),
        .shift(shift),
        .tail_in(tail_in),
        .head(head),
        .second(second)
    );

    hdf_update u_update (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(upd_ctrl),
        .gain(gain_reg),
        .west(west_reg),
        .here(head),
        .east(east),
        .result(tail_in)
    );

    assign out_valid = out_valid_reg;
    assign cell_value = cell_value_reg;
    assign step_done = step_done_reg;

`ifndef SYNTHESIS
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == hdf_pkg::ST_RUN) && (cnt_reg == '0))
        else $error("word accepted without starting a pass");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hdf_pkg::ST_RUN) |-> (cnt_reg <= CNT_W'(CELLS)))
        else $error("pass counter past the ring length");

    a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_done) |-> (cell_value == '0))
        else $error("step result carries a nonzero value");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("finished word not presented");
`endif

endmodule

@@ dv/heat_diffusion_ftcs_step_tb.sv @@
// self-checking testbench for the heat diffusion step block
`timescale 1ns / 1ps

module heat_diffusion_ftcs_step_tb;

    localparam int CELLS = 256;
    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic [hdf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 3000;
    localparam int PHASE_ITEMS = 138;

    typedef struct packed {
        logic       mode;
        logic [7:0] idx;
    } cmd_t;

    typedef struct packed {
        logic signed [hdf_pkg::VAL_W-1:0] value;
        logic                             done;
    } reply_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               mode = MODE_STEP;
    logic [7:0]                         cell_index = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [hdf_pkg::VAL_W-1:0]   cell_value;
    logic                               step_done;
    logic                               cfg_we = 1'b0;
    logic [hdf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [15:0]                        cfg_data = '0;

    // predicted field and registers
    int     temps [CELLS];
    int     gain_k;
    int     left_k;
    int     right_k;

    cmd_t   cmds_pending [$];
    reply_t replies_due [$];
    cmd_t   next_cmd;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     errors = 0;
    int     results_seen = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;

    heat_diffusion_ftcs_step #(
        .CELLS(CELLS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_value (cell_value),
        .step_done  (step_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void set_reg(input logic [hdf_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [15:0] data);
        case (idx)
            hdf_pkg::REG_GAIN:  gain_k = int'(data);
            hdf_pkg::REG_LEFT:  left_k = int'($signed(data));
            hdf_pkg::REG_RIGHT: right_k = int'($signed(data));
            default:            ;
        endcase
    endfunction

    // one explicit diffusion step, every cell from the old values
    function automatic void diffuse_step();
        int     west;
        int     here;
        int     east;
        int     lap;
        longint prod;
        longint sum;
        west = left_k;
        for (int i = 0; i < CELLS; i++)
        begin
            here = temps[i];
            east = (i < CELLS - 1) ? temps[i + 1] : right_k;
            lap = west - 2 * here + east;
            // round to nearest, ties upward
            prod = longint'(gain_k) * longint'(lap) + 64'sd32768;
            sum = longint'(here) + (prod >>> 16);
            if (sum > 32767)
                sum = 32767;
            else if (sum < -32768)
                sum = -32768;
            temps[i] = int'(sum);
            west = here;
        end
    endfunction

    function automatic void predict_reply(input logic m, input logic [7:0] idx);
        reply_t r;
        if (m == MODE_STEP)
        begin
            diffuse_step();
            r.value = '0;
            r.done = 1'b1;
        end
        else
        begin
            r.value = hdf_pkg::VAL_W'(temps[idx]);
            r.done = 1'b0;
        end
        replies_due.push_back(r);
    endfunction

    function automatic void queue_item(input logic m, input logic [7:0] idx);
        cmd_t c;
        c.mode = m;
        c.idx = idx;
        cmds_pending.push_back(c);
    endfunction

    // reads lean toward the boundary cells where the field moves first
    function automatic void queue_random(input int count);
        logic [7:0] idx;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 1))
                idx = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 1))
                idx = 8'($urandom_range(0, 15));
            else
                idx = 8'd255 - 8'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 30)
                queue_item(MODE_STEP, idx);
            else
                queue_item(MODE_READ, idx);
        end
    endfunction

    task automatic write_reg(input logic [hdf_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        set_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cmds_pending.size() != 0 || replies_due.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_reply();
        reply_t want;
        results_seen++;
        if (replies_due.size() == 0)
        begin
            if (errors < 10)
                $display("%0t unexpected word: value %0d done %0b",
                         $realtime, cell_value, step_done);
            errors++;
        end
        else
        begin
            want = replies_due.pop_front();
            if (cell_value !== want.value || step_done !== want.done)
            begin
                if (errors < 10)
                    $display("%0t mismatch: expected value %0d done %0b, got value %0d done %0b",
                             $realtime, want.value, want.done, cell_value, step_done);
                errors++;
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_STEP;
            cell_index <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_reply(mode, cell_index);
            if (!in_valid || in_ready)
            begin
                if (cmds_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    next_cmd = cmds_pending.pop_front();
                    in_valid <= 1'b1;
                    mode <= next_cmd.mode;
                    cell_index <= next_cmd.idx;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_reply();
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            temps[i] = 0;
        gain_k = int'(hdf_pkg::GAIN_RESET);
        left_k = int'($signed(hdf_pkg::LEFT_RESET));
        right_k = int'($signed(hdf_pkg::RIGHT_RESET));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 33;
        rx_idle_pct = 48;
        @(posedge clk);

        // cleared field under the reset registers
        queue_item(MODE_READ, 8'd0);
        queue_item(MODE_READ, 8'd255);
        queue_item(MODE_STEP, 8'd0);
        queue_item(MODE_READ, 8'd0);
        queue_item(MODE_READ, 8'd1);
        queue_item(MODE_READ, 8'd255);
        queue_item(MODE_READ, 8'd254);
        queue_item(MODE_READ, 8'd128);
        queue_item(MODE_STEP, 8'd255);
        queue_item(MODE_READ, 8'd0);
        queue_item(MODE_READ, 8'd1);
        drain();

        // full gain and extreme boundaries drive the ends into saturation
        write_reg(hdf_pkg::REG_GAIN, 16'hFFFF);
        write_reg(hdf_pkg::REG_LEFT, 16'h7FFF);
        write_reg(hdf_pkg::REG_RIGHT, 16'h8000);
        write_reg(REG_UNUSED, 16'h5A5A);
        queue_item(MODE_STEP, 8'hAA);
        queue_item(MODE_STEP, 8'h55);
        queue_item(MODE_STEP, 8'h0F);
        queue_item(MODE_READ, 8'd0);
        queue_item(MODE_READ, 8'd1);
        queue_item(MODE_READ, 8'd255);
        queue_item(MODE_READ, 8'd254);
        drain();

        // zero gain leaves the field unchanged
        write_reg(hdf_pkg::REG_GAIN, 16'h0000);
        queue_item(MODE_STEP, 8'd0);
        queue_item(MODE_READ, 8'd0);
        queue_item(MODE_READ, 8'd255);
        drain();

        write_reg(hdf_pkg::REG_GAIN, 16'h4000);
        write_reg(hdf_pkg::REG_LEFT, 16'h0000);
        write_reg(hdf_pkg::REG_RIGHT, 16'h0000);
        queue_item(MODE_STEP, 8'd0);
        queue_item(MODE_READ, 8'd127);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(hdf_pkg::REG_GAIN, 16'hFFFF);
                    write_reg(hdf_pkg::REG_LEFT, 16'h8000);
                    write_reg(hdf_pkg::REG_RIGHT, 16'h7FFF);
                end
                1:
                begin
                    write_reg(hdf_pkg::REG_GAIN, 16'h0000);
                    write_reg(hdf_pkg::REG_LEFT, 16'h7FFF);
                    write_reg(hdf_pkg::REG_RIGHT, 16'h7FFF);
                end
                2:
                begin
                    write_reg(hdf_pkg::REG_GAIN, 16'h8000);
                    write_reg(hdf_pkg::REG_LEFT, 16'($urandom));
                    write_reg(hdf_pkg::REG_RIGHT, 16'($urandom));
                end
                default:
                begin
                    // mostly stable gains, now and then one that oscillates
                    if ($urandom_range(0, 3) == 0)
                        write_reg(hdf_pkg::REG_GAIN, 16'($urandom));
                    else
                        write_reg(hdf_pkg::REG_GAIN, 16'($urandom_range(0, 32767)));
                    write_reg(hdf_pkg::REG_LEFT, 16'($urandom));
                    write_reg(hdf_pkg::REG_RIGHT, 16'($urandom));
                    write_reg(REG_UNUSED, 16'($urandom));
                end
            endcase
            if (p < 2)
            begin
                tx_idle_pct = 33;
                rx_idle_pct = 48;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 48;
                rx_idle_pct = 33;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            queue_random(PHASE_ITEMS);
            drain();
        end

        repeat (CELLS + 8) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            $display("%0d expected words never arrived", replies_due.size());
            errors += replies_due.size();
        end
        if (errors == 0)
            $display("heat_diffusion_ftcs_step_tb: done, clean");
        else
            $display("heat_diffusion_ftcs_step_tb: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("heat_diffusion_ftcs_step_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/hdf_pkg.sv
src/hdf_chain.sv
src/hdf_update.sv
src/heat_diffusion_ftcs_step.sv
dv/heat_diffusion_ftcs_step_tb.sv
